@@ src/rdpr_pkg.sv @@
// Shared types and constants of the remote debug packet receiver.
package rdpr_pkg;

  // Largest payload that is accepted before the packet counts as overflowed
  localparam int unsigned MaxPayload  = 4096;
  localparam int unsigned CountWidth  = $clog2(MaxPayload + 1);
  localparam int unsigned LengthWidth = 13;

  // Framing characters
  localparam logic [7:0] CharDollar = 8'h24;
  localparam logic [7:0] CharHash   = 8'h23;
  localparam logic [7:0] CharPlus   = 8'h2B;
  localparam logic [7:0] CharMinus  = 8'h2D;

  // Parser phase codes
  localparam logic [1:0] PhIdle    = 2'd0;
  localparam logic [1:0] PhPayload = 2'd1;
  localparam logic [1:0] PhHigh    = 2'd2;
  localparam logic [1:0] PhLow     = 2'd3;

  // One result item
  typedef struct packed {
    logic                   payload_valid;
    logic [7:0]             payload_byte;
    logic                   packet_done;
    logic                   packet_good;
    logic                   send_reject;
    logic                   ack_received;
    logic                   resend_requested;
    logic [LengthWidth-1:0] payload_length;
  } rdpr_result_t;

endpackage

@@ src/rdpr_if.sv @@
// Valid/ready channel interfaces for received bytes and parser results.
interface rdpr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rdpr_out_if;
  logic                  valid;
  logic                  ready;
  rdpr_pkg::rdpr_result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ src/remote_debug_packet_receiver_unit.sv @@
// Top level of the remote debug packet receiver: byte parser and result register.
//
// Takes one received character per request on rx and returns exactly one result per
// character on res. Packets are framed as '$' payload '#' and two hex checksum digits;
// payload characters come out as they arrive, and the second digit gives the verdict,
// the payload length and an ack or reject. While idle, '+' and '-' from the partner are
// reported, and any other byte except '$' asks for a reject. The parser state updates
// in the cycle a character is accepted, and the result sits in a single output
// register, so a new character is taken every cycle as long as the result register
// is empty or is being drained in that same cycle.
module remote_debug_packet_receiver_unit (
  input  logic     clk,
  input  logic     rst,
  rdpr_in_if.sink  rx,
  rdpr_out_if.source res
);

  // Parser state
  logic [1:0]                      phase;
  logic [1:0]                      phase_next;
  logic [7:0]                      running_sum;
  logic [7:0]                      running_sum_next;
  logic [4:0]                      high_digit;
  logic [4:0]                      high_digit_next;
  logic [rdpr_pkg::CountWidth-1:0] byte_count;
  logic [rdpr_pkg::CountWidth-1:0] byte_count_next;
  logic                            overflowed;
  logic                            overflowed_next;

  rdpr_pkg::rdpr_result_t result_next;
  logic                   accept;
  logic [4:0]             digit;
  logic                   sum_ok;

  // Decode a hex character; bit 4 marks a non-hex character
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = {1'b0, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = {1'b0, 4'(c - 8'h37)};
    end else begin
      v = 5'h10;
    end
    return v;
  endfunction

  // Take a new request while the result register is empty or draining
  assign rx.ready = !res.valid || res.ready;
  assign accept   = rx.valid && rx.ready;

  assign digit  = hex_value(rx.rx_byte);
  assign sum_ok = !overflowed
                  && (high_digit == {1'b0, running_sum[7:4]})
                  && (digit == {1'b0, running_sum[3:0]});

  // Advance the parser for one character
  always_comb begin
    phase_next       = phase;
    running_sum_next = running_sum;
    high_digit_next  = high_digit;
    byte_count_next  = byte_count;
    overflowed_next  = overflowed;
    result_next      = '0;
    case (phase)
      rdpr_pkg::PhIdle: begin
        if (rx.rx_byte == rdpr_pkg::CharDollar) begin
          phase_next       = rdpr_pkg::PhPayload;
          running_sum_next = '0;
          byte_count_next  = '0;
          overflowed_next  = 1'b0;
          high_digit_next  = '0;
        end else if (rx.rx_byte == rdpr_pkg::CharPlus) begin
          result_next.ack_received = 1'b1;
        end else if (rx.rx_byte == rdpr_pkg::CharMinus) begin
          result_next.resend_requested = 1'b1;
        end else begin
          result_next.send_reject = 1'b1;
        end
      end
      rdpr_pkg::PhPayload: begin
        if (rx.rx_byte == rdpr_pkg::CharHash) begin
          phase_next = rdpr_pkg::PhHigh;
        end else if (byte_count < rdpr_pkg::CountWidth'(rdpr_pkg::MaxPayload)) begin
          result_next.payload_valid = 1'b1;
          result_next.payload_byte  = rx.rx_byte;
          running_sum_next          = running_sum + rx.rx_byte;
          byte_count_next           = byte_count + 1'b1;
        end else begin
          // drop bytes past the limit
          overflowed_next = 1'b1;
        end
      end
      rdpr_pkg::PhHigh: begin
        high_digit_next = digit;
        phase_next      = rdpr_pkg::PhLow;
      end
      rdpr_pkg::PhLow: begin
        result_next.packet_done    = 1'b1;
        result_next.packet_good    = sum_ok;
        result_next.send_reject    = !sum_ok;
        result_next.payload_length = rdpr_pkg::LengthWidth'(byte_count);
        phase_next                 = rdpr_pkg::PhIdle;
      end
      default: begin
        phase_next = rdpr_pkg::PhIdle;
      end
    endcase
  end

  // Update state on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= rdpr_pkg::PhIdle;
      running_sum <= '0;
      high_digit  <= '0;
      byte_count  <= '0;
      overflowed  <= 1'b0;
    end else if (accept) begin
      phase       <= phase_next;
      running_sum <= running_sum_next;
      high_digit  <= high_digit_next;
      byte_count  <= byte_count_next;
      overflowed  <= overflowed_next;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (rx.ready) begin
      res.valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res.data <= result_next;
    end
  end

`ifndef ASSERT_OFF
  // Second checksum digit always finishes a packet
  a_done_on_low: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == rdpr_pkg::PhLow) |=> (res.valid && res.data.packet_done))
    else $error("low checksum digit did not finish the packet");

  // Byte count never passes the payload limit
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= rdpr_pkg::CountWidth'(rdpr_pkg::MaxPayload))
    else $error("payload byte count beyond limit");

  // A byte past the limit marks the packet as overflowed
  a_overflow: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == rdpr_pkg::PhPayload && rx.rx_byte != rdpr_pkg::CharHash
     && byte_count == rdpr_pkg::CountWidth'(rdpr_pkg::MaxPayload))
    |=> (overflowed && !res.data.payload_valid))
    else $error("overflow byte not flagged");

  // Result kinds are exclusive, and a good packet is never rejected
  a_kinds: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> ($onehot0({res.data.payload_valid, res.data.packet_done,
                             res.data.ack_received, res.data.resend_requested})
                   && !(res.data.packet_good && res.data.send_reject)
                   && (!res.data.packet_good || res.data.packet_done)))
    else $error("inconsistent result flags");
`endif

endmodule

@@ verif/remote_debug_packet_receiver_unit_tb.sv @@
// Testbench for the remote debug packet receiver: random and directed framing with self-check.
module remote_debug_packet_receiver_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rdpr_pkg::*;

  localparam int unsigned RandomChars = 1300;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned IdlePercent = 29;
  localparam int unsigned HoldStart   = 500;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned CalmFirst   = 1200;
  localparam int unsigned CalmLast    = 1800;
  localparam int unsigned DrainCycles = 8;

  // Characters used to build checksum digits and junk
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChLetX  = 8'h78;
  localparam logic [7:0] ChLetG  = 8'h67;

  typedef logic [7:0] char_q_t[$];
  typedef enum int {SumGood, SumWrong, HighNotHex, LowNotHex} check_mode_t;

  logic clk;
  logic rst;
  int unsigned cyc = 0;
  bit calm;
  int unsigned fail_count = 0;
  int unsigned hold_left;

  rdpr_in_if  rx_ch ();
  rdpr_out_if res_ch ();

  remote_debug_packet_receiver_unit dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .res (res_ch)
  );

  // Characters waiting to be offered, and parser outputs predicted for accepted ones
  char_q_t pending_chars;
  rdpr_result_t predicted_outputs[$];
  rdpr_result_t seen_out;
  rdpr_result_t want_out;

  // Shadow parser state
  logic [1:0]            ph = PhIdle;
  logic [7:0]            csum = '0;
  logic [4:0]            hi_dig = '0;
  logic [CountWidth-1:0] body_len = '0;
  logic                  ovf = 1'b0;

  int unsigned n_chars, n_good, n_bad, n_acks, n_resends, n_junk;

  // Decode one checksum character; bit 4 marks a non-hex character
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= ChZero && c <= ChZero + 8'd9) return {1'b0, 4'(c - ChZero)};
    if (c >= ChLowA && c <= ChLowA + 8'd5) return {1'b0, 4'(c - ChLowA + 8'd10)};
    if (c >= ChUpA && c <= ChUpA + 8'd5) return {1'b0, 4'(c - ChUpA + 8'd10)};
    return 5'h10;
  endfunction

  // Advance the shadow parser by one character and return the expected output
  function rdpr_result_t deframe_char(input logic [7:0] c);
    rdpr_result_t r;
    logic [4:0] lo;
    r = '0;
    case (ph)
      PhIdle: begin
        if (c == CharDollar) begin
          ph = PhPayload;
          csum = '0;
          body_len = '0;
          ovf = 1'b0;
          hi_dig = '0;
        end else if (c == CharPlus) begin
          r.ack_received = 1'b1;
          n_acks++;
        end else if (c == CharMinus) begin
          r.resend_requested = 1'b1;
          n_resends++;
        end else begin
          r.send_reject = 1'b1;
          n_junk++;
        end
      end
      PhPayload: begin
        if (c == CharHash) begin
          ph = PhHigh;
        end else if (body_len < MaxPayload) begin
          r.payload_valid = 1'b1;
          r.payload_byte = c;
          csum = csum + c;
          body_len = body_len + 1'b1;
        end else begin
          ovf = 1'b1;
        end
      end
      PhHigh: begin
        hi_dig = hex_nibble(c);
        ph = PhLow;
      end
      default: begin
        lo = hex_nibble(c);
        r.packet_done = 1'b1;
        r.packet_good = !ovf && !hi_dig[4] && !lo[4] &&
                        hi_dig[3:0] == csum[7:4] && lo[3:0] == csum[3:0];
        r.send_reject = !r.packet_good;
        r.payload_length = LengthWidth'(body_len);
        if (r.packet_good) n_good++;
        else n_bad++;
        ph = PhIdle;
      end
    endcase
    return r;
  endfunction

  function automatic logic [7:0] nibble_char(input logic [3:0] nib, input bit upper);
    if (nib < 4'd10) return ChZero + 8'(nib);
    return (upper ? ChUpA : ChLowA) + 8'(nib) - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    logic [4:0] d;
    do begin
      c = 8'($urandom_range(255));
      d = hex_nibble(c);
    end while (!d[4]);
    return c;
  endfunction

  function automatic char_q_t random_body(input int unsigned len);
    char_q_t b;
    logic [7:0] c;
    repeat (len) begin
      do c = 8'($urandom_range(255)); while (c == CharHash);
      b.push_back(c);
    end
    return b;
  endfunction

  // Queue one framed packet; the checksum covers only bytes that fit in the payload limit
  task automatic frame_packet(input char_q_t body, input check_mode_t mode, input bit upper);
    logic [7:0] sum;
    logic [7:0] hi_c;
    logic [7:0] lo_c;
    sum = '0;
    pending_chars.push_back(CharDollar);
    foreach (body[i]) begin
      pending_chars.push_back(body[i]);
      if (i < MaxPayload) sum = sum + body[i];
    end
    if (mode == SumWrong) sum = sum ^ 8'($urandom_range(1, 255));
    hi_c = nibble_char(sum[7:4], upper);
    lo_c = nibble_char(sum[3:0], upper);
    if (mode == HighNotHex) hi_c = non_hex_char();
    if (mode == LowNotHex) lo_c = non_hex_char();
    pending_chars.push_back(CharHash);
    pending_chars.push_back(hi_c);
    pending_chars.push_back(lo_c);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Cycle count, calm window and timeout
  assign calm = cyc >= CalmFirst && cyc < CalmLast;

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Driver: offer the head of the pending queue, hold it until accepted
  always @(posedge clk) begin
    if (rst) begin
      rx_ch.valid <= 1'b0;
    end else begin
      if (rx_ch.valid && rx_ch.ready) begin
        predicted_outputs.push_back(deframe_char(rx_ch.rx_byte));
        void'(pending_chars.pop_front());
        n_chars++;
      end
      if (rx_ch.valid && !rx_ch.ready) begin
        rx_ch.valid <= 1'b1;
      end else if (pending_chars.size() != 0 &&
                   (calm || $urandom_range(99) >= IdlePercent)) begin
        rx_ch.valid <= 1'b1;
        rx_ch.rx_byte <= pending_chars[0];
      end else begin
        rx_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver ready: random stalls plus one long hold-off to back up the input
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      hold_left <= 0;
    end else if (cyc == HoldStart) begin
      res_ch.ready <= 1'b0;
      hold_left <= HoldCycles;
    end else if (hold_left != 0) begin
      res_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      res_ch.ready <= calm || $urandom_range(99) >= IdlePercent;
    end
  end

  // Monitor: compare each accepted output with the oldest prediction
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      seen_out = res_ch.data;
      if (predicted_outputs.size() == 0) begin
        $error("output with no prediction pending");
        fail_count++;
      end else begin
        want_out = predicted_outputs.pop_front();
        check_field("payload_valid", want_out.payload_valid, seen_out.payload_valid);
        check_field("payload_byte", want_out.payload_byte, seen_out.payload_byte);
        check_field("packet_done", want_out.packet_done, seen_out.packet_done);
        check_field("packet_good", want_out.packet_good, seen_out.packet_good);
        check_field("send_reject", want_out.send_reject, seen_out.send_reject);
        check_field("ack_received", want_out.ack_received, seen_out.ack_received);
        check_field("resend_requested", want_out.resend_requested,
                    seen_out.resend_requested);
        check_field("payload_length", want_out.payload_length, seen_out.payload_length);
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int unsigned pick;
    int unsigned len;
    check_mode_t mode;
    char_q_t empty_body;

    clk = 1'b0;
    rst = 1'b1;

    // Idle characters: ack, resend, and rejected junk including a stray hash
    pending_chars.push_back(CharPlus);
    pending_chars.push_back(CharMinus);
    pending_chars.push_back(8'h00);
    pending_chars.push_back(8'hFF);
    pending_chars.push_back(CharHash);
    pending_chars.push_back(ChLetX);
    // Empty packet, dollar inside payload, letter digits in both cases
    frame_packet(empty_body, SumGood, 1'b0);
    frame_packet(char_q_t'{CharDollar, 8'h00, 8'hFF}, SumGood, 1'b1);
    frame_packet(char_q_t'{8'hFF, 8'hAB}, SumGood, 1'b0);
    frame_packet(char_q_t'{8'hFF, 8'hAB}, SumGood, 1'b1);
    // Bad checksum, non-hex high digit, non-hex low digit
    frame_packet(char_q_t'{8'h55}, SumWrong, 1'b1);
    pending_chars.push_back(CharDollar);
    pending_chars.push_back(8'h01);
    pending_chars.push_back(CharHash);
    pending_chars.push_back(ChLetG);
    pending_chars.push_back(ChZero + 8'd1);
    frame_packet(char_q_t'{8'h01}, LowNotHex, 1'b0);

    // Random traffic: mostly well-formed packets, some broken ones and idle noise
    while (pending_chars.size() < RandomChars) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        len = ($urandom_range(19) == 0) ? $urandom_range(200) : $urandom_range(16);
        if ($urandom_range(99) < 80) mode = SumGood;
        else mode = check_mode_t'($urandom_range(3));
        frame_packet(random_body(len), mode, $urandom_range(1));
      end else if (pick < 80) begin
        pending_chars.push_back(CharPlus);
      end else if (pick < 88) begin
        pending_chars.push_back(CharMinus);
      end else begin
        pending_chars.push_back(8'($urandom_range(255)));
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Wait for all characters and outputs, then let the pipeline drain
    while (pending_chars.size() != 0 || predicted_outputs.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d characters: %0d packets good, %0d rejected at checksum,",
             n_chars, n_good, n_bad);
    $display("%0d acks, %0d resend requests, %0d junk characters while idle",
             n_acks, n_resends, n_junk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
